// File: hdl/job_queue_with_keyed_removal_top_defines.svh
// assertion macros for the job queue block
`ifndef JOB_QUEUE_WITH_KEYED_REMOVAL_TOP_DEFINES_SVH
`define JOB_QUEUE_WITH_KEYED_REMOVAL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define JQKR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("jqkr assertion failed");
`define JQKR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("jqkr assertion failed");
`else
`define JQKR_ASSERT(name, clk, rst_n, prop)
`define JQKR_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// File: hdl/jqkr_pkg.sv
// types and codes shared by the job queue block
`default_nettype none
package jqkr_pkg;

  localparam int unsigned JobW = 16;
  localparam int unsigned PidW = 22;
  localparam int unsigned IdxW = 8;
  localparam int unsigned OpW  = 4;
  localparam int unsigned LenW = 9;
  localparam int unsigned StW  = 2;

  localparam logic [OpW-1:0] OP_INSERT     = 4'd0;
  localparam logic [OpW-1:0] OP_POP        = 4'd1;
  localparam logic [OpW-1:0] OP_PEEK       = 4'd2;
  localparam logic [OpW-1:0] OP_ITEM_AT    = 4'd3;
  localparam logic [OpW-1:0] OP_RM_JOB     = 4'd4;
  localparam logic [OpW-1:0] OP_RM_PID     = 4'd5;
  localparam logic [OpW-1:0] OP_JOB_EXISTS = 4'd6;
  localparam logic [OpW-1:0] OP_PID_EXISTS = 4'd7;
  localparam logic [OpW-1:0] OP_PID_OF_JOB = 4'd8;
  localparam logic [OpW-1:0] OP_LENGTH     = 4'd9;
  localparam logic [OpW-1:0] OP_DROP_HEAD  = 4'd10;

  localparam logic [StW-1:0] ST_OK   = 2'd0;
  localparam logic [StW-1:0] ST_MISS = 2'd1;
  localparam logic [StW-1:0] ST_FULL = 2'd2;

  typedef logic [LenW-1:0] len_t;

  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic [JobW-1:0] job_id;
    logic [PidW-1:0] pid;
    logic [IdxW-1:0] index;
  } req_t;

  typedef struct packed {
    logic [StW-1:0]  status;
    logic [JobW-1:0] out_job_id;
    logic [PidW-1:0] out_pid;
    logic [LenW-1:0] length;
  } rsp_t;

  typedef struct packed {
    logic [JobW-1:0] job_id;
    logic [PidW-1:0] pid;
  } entry_t;

endpackage
`default_nettype wire

// File: hdl/jqkr_req_if.sv
// request channel interface
`default_nettype none
interface jqkr_req_if;
  logic                        valid;
  logic                        ready;
  logic [jqkr_pkg::OpW-1:0]    operation;
  logic [jqkr_pkg::JobW-1:0]   job_id;
  logic [jqkr_pkg::PidW-1:0]   pid;
  logic [jqkr_pkg::IdxW-1:0]   index;

  modport source (output valid, output operation, output job_id, output pid, output index,
                  input ready);
  modport sink (input valid, input operation, input job_id, input pid, input index,
                output ready);
endinterface
`default_nettype wire

// File: hdl/jqkr_rsp_if.sv
// result channel interface
`default_nettype none
interface jqkr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [jqkr_pkg::StW-1:0]    status;
  logic [jqkr_pkg::JobW-1:0]   out_job_id;
  logic [jqkr_pkg::PidW-1:0]   out_pid;
  logic [jqkr_pkg::LenW-1:0]   length;

  modport source (output valid, output status, output out_job_id, output out_pid,
                  output length, input ready);
  modport sink (input valid, input status, input out_job_id, input out_pid, input length,
                output ready);
endinterface
`default_nettype wire

// File: hdl/job_queue_with_keyed_removal_top.sv
// top level of the ordered job queue with keyed removal
//
//   channel  dir  payload                               handshake
//   req_i    in   operation, job_id, pid, index         valid/ready
//   rsp_o    out  status, out_job_id, out_pid, length   valid/ready
//
// one request at a time; all entries sit in a single memory with one read
// and one write port, so entries are visited one at a time
// insert, length, unused codes, empty queue and item_at out of range read no entry
// peek and item_at read one entry; a key lookup scans from the head to the first hit
// pop, drop_head and key removal shift every later entry down; a key miss scans all
// reset clears only the state and the entry count; the memory needs no clearing pass
// a result waits in an output register; the next request is taken meanwhile and
// its own result holds the sequencer until the register frees
`default_nettype none
module job_queue_with_keyed_removal_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  jqkr_req_if.sink   req_i,
  jqkr_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  jqkr_pkg::req_t   req;
  jqkr_pkg::rsp_t   res;
  logic             res_valid;
  logic             res_ready;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  jqkr_pkg::entry_t rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  jqkr_pkg::entry_t wr_data;

  assign req = '{operation: req_i.operation,
                 job_id:    req_i.job_id,
                 pid:       req_i.pid,
                 index:     req_i.index};

  jqkr_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_i         (req),
    .req_ready_o   (req_i.ready),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready),
    .mem_rd_en_o   (rd_en),
    .mem_rd_addr_o (rd_addr),
    .mem_rd_data_i (rd_data),
    .mem_wr_en_o   (wr_en),
    .mem_wr_addr_o (wr_addr),
    .mem_wr_data_o (wr_data)
  );

  jqkr_store #(.DEPTH(DEPTH)) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  jqkr_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_data_i  (res),
    .in_ready_o (res_ready),
    .rsp_o      (rsp_o)
  );

endmodule
`default_nettype wire

// File: hdl/jqkr_store.sv
// entry memory: one write port, one registered read port
`default_nettype none
module jqkr_store #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output jqkr_pkg::entry_t              rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire jqkr_pkg::entry_t         wr_data_i
);

  jqkr_pkg::entry_t mem_q [DEPTH];
  jqkr_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// File: hdl/jqkr_ctrl.sv
// sequencer: decodes a request, walks and compacts the entry memory
`default_nettype none
`include "job_queue_with_keyed_removal_top_defines.svh"
module jqkr_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     req_valid_i,
  input  wire jqkr_pkg::req_t           req_i,
  output logic                          req_ready_o,
  output logic                          res_valid_o,
  output jqkr_pkg::rsp_t                res_o,
  input  wire logic                     res_ready_i,
  output logic                          mem_rd_en_o,
  output logic [$clog2(DEPTH)-1:0]      mem_rd_addr_o,
  input  wire jqkr_pkg::entry_t         mem_rd_data_i,
  output logic                          mem_wr_en_o,
  output logic [$clog2(DEPTH)-1:0]      mem_wr_addr_o,
  output jqkr_pkg::entry_t              mem_wr_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [CW-1:0]                count_q, count_d;
  logic [AW-1:0]                k_q, k_d;
  logic [jqkr_pkg::OpW-1:0]     op_q, op_d;
  logic [jqkr_pkg::JobW-1:0]    job_q, job_d;
  logic [jqkr_pkg::PidW-1:0]    pid_q, pid_d;
  logic [jqkr_pkg::StW-1:0]     st_q, st_d;
  jqkr_pkg::entry_t             ent_q, ent_d;

  logic          by_pid;
  logic          removes;
  logic          hit;
  logic          shift_go;
  logic [AW-1:0] shift_pos;

  assign by_pid  = (op_q == jqkr_pkg::OP_RM_PID) || (op_q == jqkr_pkg::OP_PID_EXISTS);
  assign removes = (op_q == jqkr_pkg::OP_RM_JOB) || (op_q == jqkr_pkg::OP_RM_PID);
  assign hit     = by_pid ? (mem_rd_data_i.pid == pid_q) : (mem_rd_data_i.job_id == job_q);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    k_d           = k_q;
    op_d          = op_q;
    job_d         = job_q;
    pid_d         = pid_q;
    st_d          = st_q;
    ent_d         = ent_q;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = '0;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = '0;
    mem_wr_data_o = '{job_id: req_i.job_id, pid: req_i.pid};
    res_valid_o   = 1'b0;
    shift_go      = 1'b0;
    shift_pos     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d    = req_i.operation;
          job_d   = req_i.job_id;
          pid_d   = req_i.pid;
          ent_d   = '0;
          st_d    = jqkr_pkg::ST_MISS;
          state_d = S_DONE;
          unique case (req_i.operation)
            jqkr_pkg::OP_INSERT: begin
              if (count_q == CW'(DEPTH)) begin
                st_d = jqkr_pkg::ST_FULL;
              end else begin
                mem_wr_en_o   = 1'b1;
                mem_wr_addr_o = count_q[AW-1:0];
                count_d       = count_q + 1'b1;
                st_d          = jqkr_pkg::ST_OK;
              end
            end
            jqkr_pkg::OP_POP, jqkr_pkg::OP_PEEK, jqkr_pkg::OP_DROP_HEAD: begin
              if (count_q != '0) begin
                mem_rd_en_o = 1'b1;
                state_d     = S_READ;
              end
            end
            jqkr_pkg::OP_ITEM_AT: begin
              if (jqkr_pkg::len_t'(req_i.index) < jqkr_pkg::len_t'(count_q)) begin
                mem_rd_en_o   = 1'b1;
                mem_rd_addr_o = req_i.index[AW-1:0];
                state_d       = S_READ;
              end
            end
            jqkr_pkg::OP_RM_JOB, jqkr_pkg::OP_RM_PID, jqkr_pkg::OP_JOB_EXISTS,
            jqkr_pkg::OP_PID_EXISTS, jqkr_pkg::OP_PID_OF_JOB: begin
              if (count_q != '0) begin
                mem_rd_en_o = 1'b1;
                k_d         = '0;
                state_d     = S_SCAN;
              end
            end
            jqkr_pkg::OP_LENGTH: begin
              st_d = jqkr_pkg::ST_OK;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        st_d  = jqkr_pkg::ST_OK;
        ent_d = (op_q == jqkr_pkg::OP_DROP_HEAD) ? '0 : mem_rd_data_i;
        if ((op_q == jqkr_pkg::OP_PEEK) || (op_q == jqkr_pkg::OP_ITEM_AT)) begin
          state_d = S_DONE;
        end else begin
          shift_go = 1'b1;
        end
      end
      S_SCAN: begin
        // read data belongs to entry k_q
        if (hit) begin
          ent_d = mem_rd_data_i;
          st_d  = jqkr_pkg::ST_OK;
          if (removes) begin
            shift_go  = 1'b1;
            shift_pos = k_q;
          end else begin
            state_d = S_DONE;
          end
        end else if (CW'(k_q) + CW'(1) == count_q) begin
          state_d = S_DONE;
        end else begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = k_q + 1'b1;
          k_d           = k_q + 1'b1;
        end
      end
      S_SHIFT: begin
        // move entry k_q+1 down to k_q while fetching k_q+2
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = k_q;
        mem_wr_data_o = mem_rd_data_i;
        if (CW'(k_q) + CW'(2) == count_q) begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end else begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = k_q + AW'(2);
          k_d           = k_q + 1'b1;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (shift_go) begin
      if (CW'(shift_pos) + CW'(1) == count_q) begin
        count_d = count_q - 1'b1;
        state_d = S_DONE;
      end else begin
        mem_rd_en_o   = 1'b1;
        mem_rd_addr_o = shift_pos + 1'b1;
        k_d           = shift_pos;
        state_d       = S_SHIFT;
      end
    end
  end

  assign req_ready_o = (state_q == S_IDLE);

  assign res_o = '{status:     st_q,
                   out_job_id: ent_q.job_id,
                   out_pid:    ent_q.pid,
                   length:     jqkr_pkg::len_t'(count_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    op_q  <= op_d;
    job_q <= job_d;
    pid_q <= pid_d;
    st_q  <= st_d;
    ent_q <= ent_d;
  end

  `JQKR_ASSERT_ALWAYS(a_count_bound, clk_i, count_q <= CW'(DEPTH))
  `JQKR_ASSERT(a_rd_in_range, clk_i, rst_ni, mem_rd_en_o |-> (CW'(mem_rd_addr_o) < count_q))
  `JQKR_ASSERT(a_wr_in_range, clk_i, rst_ni, mem_wr_en_o |-> (CW'(mem_wr_addr_o) <= count_q))
  `JQKR_ASSERT(a_count_step, clk_i, rst_ni,
    (count_q != $past(count_q)) |-> (({1'b0, count_q} == {1'b0, $past(count_q)} + 1'b1) ||
    ({1'b0, count_q} + 1'b1 == {1'b0, $past(count_q)})))

endmodule
`default_nettype wire

// File: hdl/jqkr_out.sv
// result register between the sequencer and the result channel
`default_nettype none
module jqkr_out (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  input  wire jqkr_pkg::rsp_t in_data_i,
  output logic        in_ready_o,
  jqkr_rsp_if.source  rsp_o
);

  logic           valid_q;
  jqkr_pkg::rsp_t data_q;

  assign in_ready_o = !valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign rsp_o.valid      = valid_q;
  assign rsp_o.status     = data_q.status;
  assign rsp_o.out_job_id = data_q.out_job_id;
  assign rsp_o.out_pid    = data_q.out_pid;
  assign rsp_o.length     = data_q.length;

endmodule
`default_nettype wire

// File: tb/job_queue_with_keyed_removal_top_test.sv
// testbench for the job queue with keyed removal: mirrored queue, random traffic, result checks
module job_queue_with_keyed_removal_top_test;
  import jqkr_pkg::*;

  localparam int QDepth = 16;
  localparam int ItemsRandom = 1050;
  localparam int HoldCycles = 400;
  localparam logic [OpW-1:0] OpUnusedLow = OP_DROP_HEAD + 4'd1;
  localparam logic [OpW-1:0] OpUnusedTop = '1;

  typedef enum int {SC_FILL, SC_DRAIN, SC_MIX} scene_e;

  // mirror of the queue contents and the results it owes
  class queue_mirror;
    entry_t      slots[$];
    rsp_t        rsps_due[$];
    int unsigned n_requests;
    int unsigned n_checked;
    int unsigned n_errors;
    int unsigned n_full;
    int unsigned n_hits;
    int unsigned op_count[16];

    function rsp_t run_job_op(req_t r);
      rsp_t res;
      int   n;
      int   pos;
      bit   by_pid;
      res = '0;
      res.status = ST_MISS;
      n = slots.size();
      pos = -1;
      by_pid = (r.operation == OP_RM_PID) || (r.operation == OP_PID_EXISTS);
      case (r.operation)
        OP_INSERT: begin
          if (n >= QDepth) begin
            res.status = ST_FULL;
            n_full++;
          end else begin
            slots.push_back(entry_t'{job_id: r.job_id, pid: r.pid});
            res.status = ST_OK;
          end
        end
        OP_POP, OP_PEEK, OP_DROP_HEAD: begin
          if (n > 0) begin
            res.status = ST_OK;
            if (r.operation != OP_DROP_HEAD) begin
              res.out_job_id = slots[0].job_id;
              res.out_pid = slots[0].pid;
            end
            if (r.operation != OP_PEEK) void'(slots.pop_front());
          end
        end
        OP_ITEM_AT: begin
          if (int'(r.index) < n) begin
            res.status = ST_OK;
            res.out_job_id = slots[r.index].job_id;
            res.out_pid = slots[r.index].pid;
          end
        end
        OP_RM_JOB, OP_RM_PID, OP_JOB_EXISTS, OP_PID_EXISTS, OP_PID_OF_JOB: begin
          // first match from the head wins
          for (int k = 0; k < n && pos < 0; k++) begin
            if (by_pid ? (slots[k].pid == r.pid) : (slots[k].job_id == r.job_id)) pos = k;
          end
          if (pos >= 0) begin
            res.status = ST_OK;
            res.out_job_id = slots[pos].job_id;
            res.out_pid = slots[pos].pid;
            n_hits++;
            if (r.operation == OP_RM_JOB || r.operation == OP_RM_PID) slots.delete(pos);
          end
        end
        OP_LENGTH: res.status = ST_OK;
        default: ;
      endcase
      res.length = len_t'(slots.size());
      return res;
    endfunction

    function void note_request(req_t r);
      n_requests++;
      op_count[r.operation]++;
      rsps_due.push_back(run_job_op(r));
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (rsps_due.size() == 0) begin
        $error("result with nothing outstanding: status %0d job %0h pid %0h length %0d",
               got.status, got.out_job_id, got.out_pid, got.length);
        n_errors++;
        return;
      end
      want = rsps_due.pop_front();
      n_checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        n_errors++;
      end
      if (got.out_job_id !== want.out_job_id) begin
        $error("out_job_id: expected %0h, actual %0h", want.out_job_id, got.out_job_id);
        n_errors++;
      end
      if (got.out_pid !== want.out_pid) begin
        $error("out_pid: expected %0h, actual %0h", want.out_pid, got.out_pid);
        n_errors++;
      end
      if (got.length !== want.length) begin
        $error("length: expected %0d, actual %0d", want.length, got.length);
        n_errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  jqkr_req_if req_bus ();
  jqkr_rsp_if rsp_bus ();

  job_queue_with_keyed_removal_top #(
    .DEPTH (QDepth)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  queue_mirror jobs = new();
  int burst_left;
  bit valid_high;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic req_t mk_req(logic [OpW-1:0] op, logic [JobW-1:0] j,
                                  logic [PidW-1:0] p, logic [IdxW-1:0] ix);
    req_t r;
    r.operation = op;
    r.job_id = j;
    r.pid = p;
    r.index = ix;
    return r;
  endfunction

  // random request shaped by the current scene and the mirrored contents
  function automatic req_t pick_request(scene_e scene);
    req_t r;
    int   n;
    int   k;
    int   roll;
    n = jobs.slots.size();
    r.job_id = $urandom_range(0, 1) ? JobW'($urandom_range(0, 7)) : JobW'($urandom);
    r.pid = $urandom_range(0, 1) ? PidW'($urandom_range(0, 3)) : PidW'($urandom);
    r.index = ($urandom_range(0, 4) == 0) ? IdxW'($urandom) : IdxW'($urandom_range(0, n + 1));
    roll = $urandom_range(0, 99);
    case (scene)
      SC_FILL: r.operation = OP_INSERT;
      SC_DRAIN: begin
        case ($urandom_range(0, 3))
          0: r.operation = OP_POP;
          1: r.operation = OP_DROP_HEAD;
          2: r.operation = OP_RM_JOB;
          default: r.operation = OP_RM_PID;
        endcase
        roll = 100;
      end
      default: begin
        if (roll < 30) r.operation = OP_INSERT;
        else if (roll < 95) r.operation = OpW'($urandom_range(OP_POP, OP_DROP_HEAD));
        else r.operation = OpW'($urandom_range(OpUnusedLow, OpUnusedTop));
      end
    endcase
    // keys mostly taken from live entries so matches happen
    if (n > 0 && r.operation != OP_INSERT && $urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, n - 1);
      r.job_id = jobs.slots[k].job_id;
      r.pid = jobs.slots[k].pid;
    end
    return r;
  endfunction

  task automatic push_request(input req_t r);
    int gap;
    req_bus.valid <= 1'b1;
    valid_high = 1'b1;
    req_bus.operation <= r.operation;
    req_bus.job_id <= r.job_id;
    req_bus.pid <= r.pid;
    req_bus.index <= r.index;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    jobs.note_request(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      req_bus.valid <= 1'b0;
      valid_high = 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 15);
    end
  endtask

  task automatic hold_until_drained();
    if (valid_high) begin
      req_bus.valid <= 1'b0;
      valid_high = 1'b0;
    end
    @(posedge clk_i);
    while (jobs.rsps_due.size() != 0) @(posedge clk_i);
  endtask

  // request side
  initial begin
    req_t   plan[$];
    scene_e scene;
    int     roll;
    int     goal;
    bit     paused;
    rst_ni <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.operation <= OP_LENGTH;
    req_bus.job_id <= '0;
    req_bus.pid <= '0;
    req_bus.index <= '0;
    valid_high = 1'b0;
    burst_left = 3;
    paused = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, extremes, duplicates, first match, index bounds
    plan.push_back(mk_req(OP_POP, '0, '0, '0));
    plan.push_back(mk_req(OP_PEEK, '0, '0, '0));
    plan.push_back(mk_req(OP_DROP_HEAD, '0, '0, '0));
    plan.push_back(mk_req(OP_ITEM_AT, '0, '0, '0));
    plan.push_back(mk_req(OP_RM_PID, '0, '0, '0));
    plan.push_back(mk_req(OP_LENGTH, '0, '0, '0));
    plan.push_back(mk_req(OpUnusedTop, '1, '1, '1));
    plan.push_back(mk_req(OP_INSERT, '1, '1, '0));
    plan.push_back(mk_req(OP_INSERT, '0, '0, '1));
    plan.push_back(mk_req(OP_INSERT, 16'h1234, 22'h2aaaaa, '0));
    plan.push_back(mk_req(OP_INSERT, 16'h1234, 22'h155555, '0));
    plan.push_back(mk_req(OP_PEEK, '0, '0, '0));
    plan.push_back(mk_req(OP_ITEM_AT, '0, '0, 8'd3));
    plan.push_back(mk_req(OP_ITEM_AT, '0, '0, 8'd4));
    plan.push_back(mk_req(OP_ITEM_AT, '0, '0, '1));
    plan.push_back(mk_req(OP_PID_OF_JOB, 16'h1234, '0, '0));
    plan.push_back(mk_req(OP_JOB_EXISTS, '0, '1, '0));
    plan.push_back(mk_req(OP_PID_EXISTS, '0, '1, '0));
    plan.push_back(mk_req(OP_RM_JOB, 16'h1234, '0, '0));
    plan.push_back(mk_req(OP_RM_PID, '1, 22'h155555, '0));
    plan.push_back(mk_req(OP_POP, '0, '0, '0));
    plan.push_back(mk_req(OP_DROP_HEAD, '0, '0, '0));
    plan.push_back(mk_req(OpUnusedLow, '0, '0, '0));
    plan.push_back(mk_req(OP_LENGTH, '0, '0, '0));
    foreach (plan[i]) push_request(plan[i]);
    hold_until_drained();

    goal = jobs.n_requests + ItemsRandom;
    scene = SC_FILL;
    while (jobs.n_requests < goal) begin
      case (scene)
        SC_FILL: begin
          while (jobs.slots.size() < QDepth) push_request(pick_request(SC_FILL));
          repeat ($urandom_range(1, 3)) push_request(pick_request(SC_FILL));
        end
        SC_DRAIN: begin
          while (jobs.slots.size() > 0) push_request(pick_request(SC_DRAIN));
          repeat ($urandom_range(1, 2)) push_request(pick_request(SC_DRAIN));
        end
        default: repeat ($urandom_range(5, 40)) push_request(pick_request(SC_MIX));
      endcase
      if (!paused && jobs.n_requests >= goal - ItemsRandom / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      roll = $urandom_range(0, 9);
      scene = (roll < 2) ? SC_FILL : (roll < 4) ? SC_DRAIN : SC_MIX;
    end

    hold_until_drained();
    repeat (2 * QDepth + 8) @(posedge clk_i);
    $display("sent %0d requests and checked %0d results; %0d key hits, %0d inserts refused",
             jobs.n_requests, jobs.n_checked, jobs.n_hits, jobs.n_full);
    $display("requests per code 0..15: %p", jobs.op_count);
    if (jobs.n_errors == 0 && jobs.rsps_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side: stall patterns plus one long hold-off to back the queue up
  initial begin
    int  mode;
    int  span;
    int  tick;
    int  hold_left;
    bit  held;
    bit  rdy;
    held = 1'b0;
    hold_left = 0;
    tick = 0;
    rsp_bus.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 80);
      for (int c = 0; c < span; c++) begin
        if (!held && jobs.n_requests >= 300) begin
          held = 1'b1;
          hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
          rdy = 1'b0;
          hold_left--;
        end else begin
          case (mode)
            0: rdy = 1'b1;
            1: rdy = $urandom_range(0, 1);
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = (tick % 4) != 3;
          endcase
        end
        tick++;
        rsp_bus.ready <= rdy;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : rsp_watch
    rsp_t got;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      got.status = rsp_bus.status;
      got.out_job_id = rsp_bus.out_job_id;
      got.out_pid = rsp_bus.out_pid;
      got.length = rsp_bus.length;
      jobs.check_result(got);
    end
  end

endmodule
